FILE: sv/tpf_pkg.sv
// tpf_pkg: shared types, constants and helpers of the tangential propulsion force block.
// Used by tpf_sqrt, tpf_div and the top level; depends on nothing.
package tpf_pkg;

  localparam int NUM_TYPES_DEF       = 4;
  localparam int ATOM_INDEX_BITS_DEF = 20;

  // pipeline depths of the iterative units
  localparam int SQRT_LAT = 32;   // one root bit per stage
  localparam int DIV_LAT  = 33;   // overflow check plus one quotient bit per stage

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_STR_ONE   = 3'd0,
    REG_STR_TWO   = 3'd1,
    REG_STR_THREE = 3'd2,
    REG_STR_FOUR  = 3'd3,
    REG_ALWAYS    = 3'd4,
    REG_LOCAL_CNT = 3'd5
  } reg_idx_e;

  // per-item sideband carried alongside the arithmetic
  typedef struct packed {
    logic [19:0]      idx;
    logic             app;
    logic             last;
    logic             zero;
    logic             sneg;
    logic [31:0]      smag;
    logic [2:0]       dneg;
    logic [2:0][30:0] m;
  } side_t;

  // sign and saturate one force magnitude
  function automatic logic [31:0] force_sat(logic [31:0] q, logic ovf, logic neg, logic zero);
    logic [31:0] mag;
    mag = '0;
    if (zero) begin
      return '0;
    end
    if (neg) begin
      mag = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : q;
      return 32'(-mag);
    end
    return (ovf || q[31]) ? 32'h7FFF_FFFF : q;
  endfunction

endpackage

FILE: sv/tangential_propulsion_force.sv
// Tangential propulsion force: per-angle force increment strength * d / |d| for the middle atom.
// Uses tpf_pkg, tpf_sqrt (length of d) and tpf_div (normalising division, three lanes).
//
// Channels: the slave stream carries one angle item per beat (positions of the first and
// third atoms and the middle atom index in tdata, angle type in tuser, end of list in
// tlast). The master stream returns one force item per angle in the same order (force
// components and target atom in tdata, applied and zero-length flags in tuser, end of list
// in tlast). The APB port holds the four type strengths, the always-apply flag and the
// local atom count; write it only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. The result reaches the output
// register through the 32-stage square root and the 33-stage divider in series.
// Reset clears all configuration registers to zero and empties the pipeline.
// When the receiver stalls, the finished item waits in the output register; the pipeline
// keeps accepting until an item reaches its last stage, then the whole pipeline holds.
module tangential_propulsion_force
  import tpf_pkg::*;
#(
  parameter int NUM_TYPES       = NUM_TYPES_DEF,
  parameter int ATOM_INDEX_BITS = ATOM_INDEX_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // angle items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_x, first_y, first_z, third_x, third_y, third_z, middle_atom, 4 bits zero pad
  input  logic [215:0] s_axis_tdata,
  // angle_type
  input  logic [2:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  // force items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // force_x, force_y, force_z, target_atom, 4 bits zero pad
  output logic [119:0] m_axis_tdata,
  // applied, zero_length
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IDX_W  = (ATOM_INDEX_BITS < 20) ? ATOM_INDEX_BITS : 20;
  localparam int ST_SQ  = 4;                  // radicand register
  localparam int ST_RT  = ST_SQ + SQRT_LAT;   // root out
  localparam int ST_PR  = ST_RT + 1;          // products
  localparam int ST_NM  = ST_PR + 1;          // rounded dividends
  localparam int LAST   = ST_NM + DIV_LAT;    // quotients out

  // configuration registers
  logic [3:0][31:0] str_q;
  logic             always_q;
  logic [20:0]      lcnt_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q    <= '0;
      always_q <= 1'b0;
      lcnt_q   <= '0;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_STR_ONE:   str_q[0] <= pwdata;
        REG_STR_TWO:   str_q[1] <= pwdata;
        REG_STR_THREE: str_q[2] <= pwdata;
        REG_STR_FOUR:  str_q[3] <= pwdata;
        REG_ALWAYS:    always_q <= pwdata[0];
        REG_LOCAL_CNT: lcnt_q   <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_STR_ONE:   prdata = str_q[0];
      REG_STR_TWO:   prdata = str_q[1];
      REG_STR_THREE: prdata = str_q[2];
      REG_STR_FOUR:  prdata = str_q[3];
      REG_ALWAYS:    prdata = {31'd0, always_q};
      REG_LOCAL_CNT: prdata = {11'd0, lcnt_q};
      default:       prdata = '0;
    endcase
  end

  // flow control: pipeline holds only when its last stage cannot move on
  logic [LAST:1] vld_q;
  logic          outv_q;
  logic          en;
  logic          out_ld;

  assign en            = !(vld_q[LAST] && outv_q && !m_axis_tready);
  assign out_ld        = !outv_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      outv_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LAST-1:1], s_axis_tvalid};
      end
      if (out_ld) begin
        outv_q <= vld_q[LAST];
      end
    end
  end

  // input decode
  logic [2:0][31:0] first_pos;
  logic [2:0][31:0] third_pos;
  logic [19:0]      idx_in;
  logic [31:0]      str_sel;
  logic [2:0]       atype;

  assign first_pos = s_axis_tdata[95:0];
  assign third_pos = s_axis_tdata[191:96];
  assign idx_in    = 20'(s_axis_tdata[192 +: IDX_W]);
  assign atype     = s_axis_tuser;

  always_comb begin
    str_sel = '0;
    if (atype >= 3'd1 && 32'(atype) <= NUM_TYPES) begin
      str_sel = str_q[2'(atype - 3'd1)];
    end
  end

  // stage 1: differences
  logic [2:0][32:0] d1_q;
  logic [31:0]      str1_q;
  logic [19:0]      idx1_q;
  logic             app1_q;
  logic             last1_q;

  // stage 2: magnitudes, shared scaling, signs
  side_t side2_d;
  logic [2:0][32:0] dmag;
  logic             shr;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dmag[k] = d1_q[k][32] ? 33'(-d1_q[k]) : d1_q[k];
    end
    shr = (dmag[0][32:31] != 2'b00) || (dmag[1][32:31] != 2'b00) ||
          (dmag[2][32:31] != 2'b00);
    side2_d.idx  = idx1_q;
    side2_d.app  = app1_q;
    side2_d.last = last1_q;
    side2_d.zero = (d1_q == '0);
    side2_d.sneg = str1_q[31];
    side2_d.smag = str1_q[31] ? 32'(-str1_q) : str1_q;
    for (int k = 0; k < 3; k++) begin
      side2_d.dneg[k] = d1_q[k][32];
      side2_d.m[k]    = shr ? dmag[k][31:1] : dmag[k][30:0];
    end
  end

  side_t            side_q [2:LAST];
  logic [2:0][61:0] sq3_q;
  logic [63:0]      sum4_q;
  logic [31:0]      root;
  logic [31:0]      r_pr_q;
  logic [31:0]      r_nm_q;
  logic [2:0][62:0] prod_q;
  logic [2:0][63:0] num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      for (int k = 0; k < 3; k++) begin
        d1_q[k] <= 33'($signed(third_pos[k])) - 33'($signed(first_pos[k]));
      end
      str1_q  <= str_sel;
      idx1_q  <= idx_in;
      app1_q  <= always_q || ({1'b0, idx_in} < lcnt_q);
      last1_q <= s_axis_tlast;
      // sideband delay line
      side_q[2] <= side2_d;
      for (int k = 3; k <= LAST; k++) begin
        side_q[k] <= side_q[k-1];
      end
      // stage 3: squares
      for (int k = 0; k < 3; k++) begin
        sq3_q[k] <= side_q[2].m[k] * side_q[2].m[k];
      end
      // stage 4: radicand
      sum4_q <= 64'(sq3_q[0]) + 64'(sq3_q[1]) + 64'(sq3_q[2]);
      // products after the root
      r_pr_q <= root;
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= side_q[ST_RT].smag * side_q[ST_RT].m[k];
      end
      // round to nearest: add half the divisor
      r_nm_q <= r_pr_q;
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= 64'(prod_q[k]) + 64'(r_pr_q[31:1]);
      end
    end
  end

  tpf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum4_q),
    .root_o (root)
  );

  logic [2:0][31:0] quo;
  logic [2:0]       ovf;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tpf_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[k]),
      .den_i (r_nm_q),
      .quo_o (quo[k]),
      .ovf_o (ovf[k])
    );
  end

  // output register
  logic [2:0][31:0] force_q;
  logic [19:0]      tgt_q;
  logic             app_q;
  logic             zero_q;
  logic             done_q;

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      for (int k = 0; k < 3; k++) begin
        force_q[k] <= force_sat(quo[k], ovf[k],
                                side_q[LAST].sneg ^ side_q[LAST].dneg[k],
                                side_q[LAST].zero);
      end
      tgt_q  <= side_q[LAST].idx;
      app_q  <= side_q[LAST].app;
      zero_q <= side_q[LAST].zero;
      done_q <= side_q[LAST].last;
    end
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = {4'd0, tgt_q, force_q[2], force_q[1], force_q[0]};
  assign m_axis_tuser  = {zero_q, app_q};
  assign m_axis_tlast  = done_q;

endmodule

FILE: sv/tpf_sqrt.sv
// tpf_sqrt: pipelined integer square root, 64-bit radicand, 32-bit root.
// Uses tpf_pkg for the stage count.
module tpf_sqrt
  import tpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  logic [33:0] rem_q  [SQRT_LAT];
  logic [31:0] root_q [SQRT_LAT];
  logic [63:0] rad_q  [SQRT_LAT];

  // one digit pair per stage: shift in two radicand bits, trial subtract
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    logic [33:0] rem_sh;
    logic [33:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_sh = {rem_in[31:0], rad_in[63:62]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= {rad_in[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule

FILE: sv/tpf_div.sv
// tpf_div: pipelined restoring divider, 64-bit dividend by 32-bit divisor.
// Gives 32 quotient bits and a flag for quotients of 2^32 or more; uses tpf_pkg.
module tpf_div
  import tpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [31:0] quo_o,
  output logic        ovf_o
);

  localparam int STEPS = DIV_LAT - 1;

  logic [31:0] rem_q [DIV_LAT];
  logic [31:0] low_q [DIV_LAT];
  logic [31:0] quo_q [DIV_LAT];
  logic [31:0] den_q [DIV_LAT];
  logic        ovf_q [DIV_LAT];

  // first stage: high half as partial remainder, overflow check
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[63:32];
      low_q[0] <= num_i[31:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= (num_i[63:32] >= den_i);
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [32:0] rem_sh;
    logic        take;

    assign rem_sh = {rem_q[k-1], low_q[k-1][31]};
    assign take   = (rem_sh >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? 32'(rem_sh - {1'b0, den_q[k-1]}) : rem_sh[31:0];
        low_q[k] <= {low_q[k-1][30:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][30:0], take};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[STEPS];
  assign ovf_o = ovf_q[STEPS];

endmodule

FILE: sv/tpf_checker.sv
// tpf_checker: port-level checks of the tangential propulsion force block.
// Bound to the top level below; depends on nothing else.
module tpf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  // coinciding atoms give zero force
  a_zero_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[95:0] == '0)
    else $error("zero-length item with nonzero force");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a receiver that takes items never blocks the input
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // a stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output item changed");

endmodule

bind tangential_propulsion_force tpf_checker u_tpf_checker (.*);

FILE: sim/tb_top.sv
// Self-checking bench for the tangential propulsion force block: streams angle items,
// predicts each force item in SystemVerilog or takes it typed in, compares field by field.
// Depends on tpf_pkg and tangential_propulsion_force only.
`timescale 1ns / 1ps

module tb_top
  import tpf_pkg::*;
;

  localparam int LATENCY    = 72;
  localparam int WATCHDOG   = 20000;
  localparam int RAND_ITEMS = 1430;

  typedef struct packed {
    logic signed [31:0] fx, fy, fz;
    logic [19:0]        atom;
    logic               applied, zero_len, done;
  } force_item_t;

  typedef struct {
    logic signed [31:0] p [6];
    logic [2:0]         kind;
    logic [19:0]        atom;
    logic               last;
  } angle_item_t;

  // directed row: expected force typed in where obvious
  typedef struct {
    angle_item_t a;
    bit          known;
    force_item_t f;
  } stim_row_t;

  logic clk_i = 0, rst_ni = 0;
  logic         s_axis_tvalid = 0, s_axis_tlast = 0, m_axis_tready = 0;
  logic [215:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         s_axis_tready, m_axis_tvalid, m_axis_tlast, pready;
  logic [119:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0, prdata;

  tangential_propulsion_force dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // shadow configuration
  logic signed [31:0] strength [4];
  logic               always_on;
  logic [20:0]        local_cnt;

  force_item_t expected_forces [$];
  int  errors = 0;
  int  send_idle = 0, recv_idle = 0;   // idle percentage per side
  bit  hold_recv = 0;
  bit  stim_done = 0;
  int  quiet = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic force_item_t predict_force(angle_item_t a);
    force_item_t f;
    logic signed [32:0] d [3];
    logic [63:0] m [3], mx, r, q, smag;
    logic signed [31:0] s;
    logic neg;
    logic signed [31:0] comp [3];
    for (int k = 0; k < 3; k++) begin
      d[k] = 33'(a.p[3+k]) - 33'(a.p[k]);
      m[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    while (mx >= 64'h8000_0000) begin
      for (int k = 0; k < 3; k++) m[k] >>= 1;
      mx >>= 1;
    end
    r = isqrt(m[0]*m[0] + m[1]*m[1] + m[2]*m[2]);
    s = (a.kind >= 1 && a.kind <= 4) ? strength[a.kind-1] : 0;
    smag = s < 0 ? 64'(-64'(s)) : 64'(s);
    for (int k = 0; k < 3; k++) begin
      comp[k] = 0;
      if (r != 0) begin
        q = (smag * m[k] + (r >> 1)) / r;
        neg = (s < 0) != (d[k] < 0);
        if (q != 0) begin
          if (neg) comp[k] = 32'(-(q > 64'h8000_0000 ? 64'h8000_0000 : q));
          else     comp[k] = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(q);
        end
      end
    end
    f.fx = comp[0]; f.fy = comp[1]; f.fz = comp[2];
    f.atom = a.atom;
    f.applied = always_on || ({1'b0, a.atom} < local_cnt);
    f.zero_len = (r == 0);
    f.done = a.last;
    return f;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_ALWAYS:    always_on = val[0];
      REG_LOCAL_CNT: local_cnt = val[20:0];
      default:       strength[int'(idx)] = val;
    endcase
  endtask

  task automatic send_angle(angle_item_t a, bit known, force_item_t f);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {4'b0, a.atom, a.p[5], a.p[4], a.p[3], a.p[2], a.p[1], a.p[0]};
    s_axis_tuser  <= a.kind;
    s_axis_tlast  <= a.last;
    expected_forces.push_back(known ? f : predict_force(a));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 0;
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_pos(bit near);
    case ($urandom_range(5))
      0: return near ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      1: return $signed($urandom_range(65535) << 8) - 32'sd8388608;
      default: return $urandom;
    endcase
  endfunction

  function automatic angle_item_t rand_angle();
    angle_item_t a;
    for (int k = 0; k < 6; k++) a.p[k] = rand_pos(k < 3);
    if ($urandom_range(15) == 0) for (int k = 0; k < 3; k++) a.p[k+3] = a.p[k];
    a.kind = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
    a.atom = ($urandom_range(3) == 0) ? 20'($urandom_range(1000)) : 20'($urandom);
    a.last = ($urandom_range(15) == 0);
    return a;
  endfunction

  // receiver: random back-pressure, long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni || hold_recv) m_axis_tready <= 0;
    else m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  // output checker and watchdog
  always @(posedge clk_i) begin
    force_item_t exp_f;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_forces.size() == 0) begin
          $error("force item with nothing expected");
          errors++;
        end else begin
          exp_f = expected_forces.pop_front();
          if (m_axis_tdata[31:0] !== exp_f.fx) begin
            $error("force_x exp %h got %h", exp_f.fx, m_axis_tdata[31:0]); errors++;
          end
          if (m_axis_tdata[63:32] !== exp_f.fy) begin
            $error("force_y exp %h got %h", exp_f.fy, m_axis_tdata[63:32]); errors++;
          end
          if (m_axis_tdata[95:64] !== exp_f.fz) begin
            $error("force_z exp %h got %h", exp_f.fz, m_axis_tdata[95:64]); errors++;
          end
          if (m_axis_tdata[115:96] !== exp_f.atom) begin
            $error("target_atom exp %h got %h", exp_f.atom, m_axis_tdata[115:96]); errors++;
          end
          if (m_axis_tuser[0] !== exp_f.applied) begin
            $error("applied exp %b got %b", exp_f.applied, m_axis_tuser[0]); errors++;
          end
          if (m_axis_tuser[1] !== exp_f.zero_len) begin
            $error("zero_length exp %b got %b", exp_f.zero_len, m_axis_tuser[1]); errors++;
          end
          if (m_axis_tlast !== exp_f.done) begin
            $error("done_res exp %b got %b", exp_f.done, m_axis_tlast); errors++;
          end
        end
      end
    end
  end

  // long receiver hold while the sender keeps offering
  initial begin
    wait (stim_done == 0 && rst_ni);
    wait (send_idle == 23);
    repeat (300) @(posedge clk_i);
    hold_recv = 1;
    repeat (400) @(posedge clk_i);
    hold_recv = 0;
  end

  initial begin
    stim_row_t   rows [$];
    stim_row_t   row;
    angle_item_t a;
    force_item_t f;
    for (int k = 0; k < 4; k++) strength[k] = 0;
    always_on = 0; local_cnt = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // after reset every strength is zero: zero force, nothing local
    a.p = '{0, 0, 0, 32'sh10000, 0, 0}; a.kind = 1; a.atom = 5; a.last = 0;
    row.a = a; row.known = 1; row.f = '{0, 0, 0, 20'd5, 0, 0, 0}; rows.push_back(row);
    // coinciding atoms
    a.p = '{7, -7, 3, 7, -7, 3}; a.kind = 2; a.atom = 20'hFFFFF; a.last = 1;
    row.a = a; row.f = '{0, 0, 0, 20'hFFFFF, 0, 1, 1}; rows.push_back(row);
    foreach (rows[i]) send_angle(rows[i].a, rows[i].known, rows[i].f);
    end_burst();

    write_reg(REG_STR_ONE,   32'h0001_0000);
    write_reg(REG_STR_TWO,   32'h8000_0000);
    write_reg(REG_STR_THREE, 32'h7FFF_FFFF);
    write_reg(REG_STR_FOUR,  32'hFFFF_0000);
    write_reg(REG_LOCAL_CNT, 21'h10_0000);
    rows.delete();
    row.known = 0;
    // extremes, every type, out-of-range types, huge separations
    for (int t = 0; t < 8; t++) begin
      a.p = '{32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh10000, 32'sh8000_0000};
      a.kind = 3'(t); a.atom = 20'(t * 131071); a.last = t[0];
      row.a = a; rows.push_back(row);
      a.p = '{0, 0, 0, -32'sd3, 32'sd4, 0}; a.atom = 20'hFFFFF - 20'(t);
      row.a = a; rows.push_back(row);
    end
    foreach (rows[i]) send_angle(rows[i].a, 0, f);
    end_burst();

    // random phases: idle pattern and configuration vary
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 23 : ph == 1 ? 88 : 0;
      recv_idle = ph == 0 ? 88 : ph == 1 ? 23 : 0;
      write_reg(REG_ALWAYS, ph == 1);
      write_reg(REG_LOCAL_CNT, ph == 2 ? 21'h0 : 21'($urandom_range(1048576)));
      for (int k = 0; k < 4; k++)
        write_reg(reg_idx_e'(k), ph == 2 && k == 0 ? 32'h8000_0000 : $urandom);
      for (int i = 0; i < RAND_ITEMS / 3; i++) begin
        if ($urandom_range(9) == 0) send_idle = (ph == 2) ? 0 : send_idle;
        send_angle(rand_angle(), 0, f);
      end
      end_burst();
    end
    stim_done = 1;

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
